// ===== src/ata_identify_probe_sequencer_core_defines.svh =====
// assertion macros for the identify probe sequencer
`ifndef ATA_IDENTIFY_PROBE_SEQUENCER_CORE_DEFINES_SVH
`define ATA_IDENTIFY_PROBE_SEQUENCER_CORE_DEFINES_SVH

// implication checked on every rising clock edge out of reset
`define AIPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define AIPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/aips_pkg.sv =====
// types and constants shared by the identify probe sequencer
package aips_pkg;

  typedef enum logic {
    CmdStart    = 1'b0,
    CmdComplete = 1'b1
  } command_e;

  typedef enum logic {
    KindAccess = 1'b0,
    KindReport = 1'b1
  } report_kind_e;

  typedef enum logic [1:0] {
    ResOk       = 2'd0,
    ResNoDevice = 2'd1,
    ResTimeout  = 2'd2,
    ResIoError  = 2'd3
  } result_code_e;

  localparam logic [3:0] RegData        = 4'd0;
  localparam logic [3:0] RegSectorCount = 4'd2;
  localparam logic [3:0] RegLbaMid      = 4'd4;
  localparam logic [3:0] RegLbaHigh     = 4'd5;
  localparam logic [3:0] RegDrive       = 4'd6;
  localparam logic [3:0] RegStatus      = 4'd7;
  localparam logic [3:0] RegCommand     = 4'd7;
  localparam logic [3:0] RegAltStatus   = 4'd8;

  localparam logic [7:0] DriveMaster     = 8'hA0;
  localparam logic [7:0] DriveSlave      = 8'hB0;
  localparam logic [7:0] CmdIdentify     = 8'hEC;

  localparam int unsigned StatBsy = 7;
  localparam int unsigned StatDf  = 5;
  localparam int unsigned StatDrq = 3;
  localparam int unsigned StatErr = 0;

  localparam logic [8:0] IdentifyWords = 9'd256;
  localparam logic [8:0] WordCountLo   = 9'd60;
  localparam logic [8:0] WordCountHi   = 9'd61;
  localparam logic [8:0] WordFeatures  = 9'd83;
  localparam logic [8:0] WordLbaFirst  = 9'd100;
  localparam logic [8:0] WordLbaLast   = 9'd103;
  localparam int unsigned Lba48Bit     = 10;
  localparam logic [8:0] ClearRegs     = 9'd4;

  localparam logic [31:0] PollLimitReset = 32'd1000000000;

  typedef struct packed {
    logic        command;
    logic        channel_select;
    logic        drive_select;
    logic [15:0] read_data;
  } req_t;

  typedef struct packed {
    logic        report_kind;
    logic        bus_channel;
    logic        bus_write;
    logic [3:0]  bus_reg;
    logic        bus_wide;
    logic [7:0]  bus_data;
    logic [1:0]  result_code;
    logic        is_packet_device;
    logic        lba48_supported;
    logic [63:0] sector_count;
  } rsp_t;

  function automatic rsp_t make_access(logic ch, logic wr, logic [3:0] rg, logic wide,
                                       logic [7:0] data);
    rsp_t r;
    r             = '0;
    r.report_kind = KindAccess;
    r.bus_channel = ch;
    r.bus_write   = wr;
    r.bus_reg     = rg;
    r.bus_wide    = wide;
    r.bus_data    = data;
    return r;
  endfunction

  function automatic rsp_t make_report(logic ch, result_code_e code, logic pkt, logic l48,
                                       logic [63:0] count);
    rsp_t r;
    r                  = '0;
    r.report_kind      = KindReport;
    r.bus_channel      = ch;
    r.result_code      = code;
    r.is_packet_device = pkt;
    r.lba48_supported  = l48;
    r.sector_count     = count;
    return r;
  endfunction

endpackage

// ===== src/aips_if.sv =====
// request and response stream interfaces of the identify probe sequencer
interface aips_req_if import aips_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aips_rsp_if import aips_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ata_identify_probe_sequencer_core.sv =====
// ATA PIO IDENTIFY DEVICE probe sequencer: top level
// The block takes one item per clock: a start item or a bus completion goes straight
// through the sequencer logic into the result register in the cycle it is transferred,
// so its result shows in the next cycle. The request side is
// ready whenever the result register is empty or its content is taken in the same
// cycle, so the sustained rate is one item per cycle while the downstream side keeps up.
// A start item drops any running probe; a completion while idle gives no result.
`include "ata_identify_probe_sequencer_core_defines.svh"

module ata_identify_probe_sequencer_core import aips_pkg::*; #(
  parameter int unsigned DELAY_READS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  aips_req_if.sink    req_i,
  aips_rsp_if.source  rsp_o
);

  typedef enum logic [4:0] {
    PhIdle, PhSelW, PhSelDly, PhChk1, PhBsy1,
    PhSel2W, PhSel2Dly, PhClr, PhCmd, PhChk2, PhBsy2,
    PhSigMid, PhSigHigh, PhDrq, PhData
  } phase_e;

  localparam logic [8:0] DelayCount = 9'(DELAY_READS);

  phase_e      phase_q, phase_d;
  logic [31:0] poll_limit_q;
  logic [31:0] poll_count_q, poll_count_d;
  logic [8:0]  step_index_q, step_index_d;
  logic        channel_q, channel_d;
  logic        drive_q, drive_d;
  logic        lba48_q, lba48_d;
  logic [31:0] small_q, small_d;
  logic [63:0] large_q, large_d;
  logic        sig_q, sig_d;
  logic        rsp_valid_q;
  rsp_t        rsp_q, rsp_d;
  logic        emit;
  logic        req_xfer;

  logic [7:0]  b;
  logic [15:0] word;
  logic [8:0]  step_inc;
  logic [31:0] poll_inc;
  logic        poll_timeout;
  logic [7:0]  drive_byte;
  logic [63:0] count;

  assign req_i.ready   = !rsp_valid_q || rsp_o.ready;
  assign req_xfer      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  assign word         = req_i.payload.read_data;
  assign b            = word[7:0];
  assign step_inc     = step_index_q + 9'd1;
  assign poll_inc     = poll_count_q + 32'd1;
  assign poll_timeout = poll_inc >= poll_limit_q;
  assign drive_byte   = drive_q ? DriveSlave : DriveMaster;

  always_comb begin
    phase_d      = phase_q;
    poll_count_d = poll_count_q;
    step_index_d = step_index_q;
    channel_d    = channel_q;
    drive_d      = drive_q;
    lba48_d      = lba48_q;
    small_d      = small_q;
    large_d      = large_q;
    sig_d        = sig_q;
    rsp_d        = '0;
    emit         = 1'b0;
    count        = '0;

    if (req_xfer) begin
      if (req_i.payload.command == CmdStart) begin
        channel_d    = req_i.payload.channel_select;
        drive_d      = req_i.payload.drive_select;
        lba48_d      = 1'b0;
        small_d      = '0;
        large_d      = '0;
        sig_d        = 1'b0;
        poll_count_d = '0;
        step_index_d = '0;
        phase_d      = PhSelW;
        emit         = 1'b1;
        rsp_d        = make_access(req_i.payload.channel_select, 1'b1, RegDrive, 1'b0,
                                   req_i.payload.drive_select ? DriveSlave : DriveMaster);
      end else begin
        emit = 1'b1;
        unique case (phase_q)
          PhSelW, PhSel2W: begin
            step_index_d = '0;
            phase_d      = (phase_q == PhSelW) ? PhSelDly : PhSel2Dly;
            rsp_d        = make_access(channel_q, 1'b0, RegAltStatus, 1'b0, 8'h00);
          end
          PhSelDly: begin
            step_index_d = step_inc;
            if (step_inc < DelayCount) begin
              rsp_d = make_access(channel_q, 1'b0, RegAltStatus, 1'b0, 8'h00);
            end else begin
              phase_d = PhChk1;
              rsp_d   = make_access(channel_q, 1'b0, RegStatus, 1'b0, 8'h00);
            end
          end
          PhSel2Dly: begin
            step_index_d = step_inc;
            if (step_inc < DelayCount) begin
              rsp_d = make_access(channel_q, 1'b0, RegAltStatus, 1'b0, 8'h00);
            end else begin
              step_index_d = '0;
              phase_d      = PhClr;
              rsp_d        = make_access(channel_q, 1'b1, RegSectorCount, 1'b0, 8'h00);
            end
          end
          PhChk1, PhChk2, PhSigHigh: begin
            poll_count_d = '0;
            if (phase_q != PhSigHigh && b == 8'h00) begin
              phase_d = PhIdle;
              rsp_d   = make_report(channel_q, ResNoDevice, 1'b0, 1'b0, '0);
            end else if (phase_q == PhSigHigh && (sig_q || b != 8'h00)) begin
              sig_d   = 1'b1;
              phase_d = PhIdle;
              rsp_d   = make_report(channel_q, ResNoDevice, 1'b1, 1'b0, '0);
            end else if (poll_limit_q == '0) begin
              phase_d = PhIdle;
              rsp_d   = make_report(channel_q, ResTimeout, 1'b0, 1'b0, '0);
            end else begin
              phase_d = (phase_q == PhChk1) ? PhBsy1 :
                        (phase_q == PhChk2) ? PhBsy2 : PhDrq;
              rsp_d   = make_access(channel_q, 1'b0, RegStatus, 1'b0, 8'h00);
            end
          end
          PhBsy1, PhBsy2, PhDrq: begin
            if ((phase_q != PhDrq || !b[StatBsy]) && !b[StatBsy] && phase_q == PhBsy1) begin
              phase_d = PhSel2W;
              rsp_d   = make_access(channel_q, 1'b1, RegDrive, 1'b0, drive_byte);
            end else if (!b[StatBsy] && phase_q == PhBsy2) begin
              phase_d = PhSigMid;
              rsp_d   = make_access(channel_q, 1'b0, RegLbaMid, 1'b0, 8'h00);
            end else if (!b[StatBsy] && phase_q == PhDrq && (b[StatErr] || b[StatDf])) begin
              phase_d = PhIdle;
              rsp_d   = make_report(channel_q, ResIoError, 1'b0, 1'b0, '0);
            end else if (!b[StatBsy] && phase_q == PhDrq && b[StatDrq]) begin
              step_index_d = '0;
              phase_d      = PhData;
              rsp_d        = make_access(channel_q, 1'b0, RegData, 1'b1, 8'h00);
            end else begin
              poll_count_d = poll_inc;
              if (poll_timeout) begin
                phase_d = PhIdle;
                rsp_d   = make_report(channel_q, ResTimeout, 1'b0, 1'b0, '0);
              end else begin
                rsp_d = make_access(channel_q, 1'b0, RegStatus, 1'b0, 8'h00);
              end
            end
          end
          PhClr: begin
            step_index_d = step_inc;
            if (step_inc < ClearRegs) begin
              rsp_d = make_access(channel_q, 1'b1, RegSectorCount + step_inc[3:0], 1'b0,
                                  8'h00);
            end else begin
              phase_d = PhCmd;
              rsp_d   = make_access(channel_q, 1'b1, RegCommand, 1'b0, CmdIdentify);
            end
          end
          PhCmd: begin
            phase_d = PhChk2;
            rsp_d   = make_access(channel_q, 1'b0, RegStatus, 1'b0, 8'h00);
          end
          PhSigMid: begin
            sig_d   = (b != 8'h00);
            phase_d = PhSigHigh;
            rsp_d   = make_access(channel_q, 1'b0, RegLbaHigh, 1'b0, 8'h00);
          end
          PhData: begin
            if (step_index_q == WordCountLo) begin
              small_d[15:0] = word;
            end else if (step_index_q == WordCountHi) begin
              small_d[31:16] = word;
            end else if (step_index_q == WordFeatures) begin
              lba48_d = word[Lba48Bit];
            end else if (step_index_q >= WordLbaFirst && step_index_q <= WordLbaLast) begin
              large_d[{step_index_q[1:0], 4'b0000} +: 16] = word;
            end
            step_index_d = step_inc;
            count = (lba48_d && large_d != '0) ? large_d : {32'h0, small_d};
            if (step_inc < IdentifyWords) begin
              rsp_d = make_access(channel_q, 1'b0, RegData, 1'b1, 8'h00);
            end else if (count == '0) begin
              phase_d = PhIdle;
              rsp_d   = make_report(channel_q, ResIoError, 1'b0, lba48_d, '0);
            end else begin
              phase_d = PhIdle;
              rsp_d   = make_report(channel_q, ResOk, 1'b0, lba48_d, count);
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      poll_limit_q <= PollLimitReset;
      poll_count_q <= '0;
      step_index_q <= '0;
      channel_q    <= 1'b0;
      drive_q      <= 1'b0;
      lba48_q      <= 1'b0;
      small_q      <= '0;
      large_q      <= '0;
      sig_q        <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      poll_count_q <= poll_count_d;
      step_index_q <= step_index_d;
      channel_q    <= channel_d;
      drive_q      <= drive_d;
      lba48_q      <= lba48_d;
      small_q      <= small_d;
      large_q      <= large_d;
      sig_q        <= sig_d;
      if (cfg_we_i) begin
        poll_limit_q <= cfg_wdata_i;
      end
      if (req_xfer) begin
        rsp_valid_q <= emit;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_xfer && emit) begin
      rsp_q <= rsp_d;
    end
  end

  `AIPS_ASSERT_IMP(a_access_fields_clear,
    rsp_o.valid && rsp_o.payload.report_kind == KindAccess,
    rsp_o.payload.result_code == ResOk && rsp_o.payload.sector_count == '0,
    "access request carries report fields")
  `AIPS_ASSERT_IMP(a_report_bus_clear,
    rsp_o.valid && rsp_o.payload.report_kind == KindReport,
    !rsp_o.payload.bus_write && rsp_o.payload.bus_reg == RegData && !rsp_o.payload.bus_wide,
    "report carries bus access fields")
  `AIPS_ASSERT_NEXT(a_idle_completion_silent,
    req_xfer && req_i.payload.command == CmdComplete && phase_q == PhIdle,
    !rsp_o.valid,
    "completion while idle produced a result")
  `AIPS_ASSERT_NEXT(a_start_selects_drive,
    req_xfer && req_i.payload.command == CmdStart,
    rsp_o.valid && rsp_o.payload.bus_write && rsp_o.payload.bus_reg == RegDrive,
    "start transfer did not select the drive")

endmodule

// ===== verif/tb_ata_identify_probe_sequencer_core.sv =====
// self-checking testbench for the ata identify probe sequencer core
`timescale 1ns / 1ps

module tb_ata_identify_probe_sequencer_core;
  import aips_pkg::*;

  localparam int unsigned DelayReads    = 4;
  localparam int unsigned HoldOffCycles = 50;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ItemTarget    = 450;
  localparam longint      TimeoutNs     = 64'd20_000_000;

  typedef enum logic [4:0] {
    PhIdle, PhSelWr, PhSelDly, PhChk1, PhBsy1,
    PhSel2Wr, PhSel2Dly, PhClr, PhCmd, PhChk2, PhBsy2,
    PhSigMid, PhSigHigh, PhDrq, PhData
  } probe_phase_e;

  typedef enum int {
    CountRandom, CountNoLarge, CountZero, CountNo48, CountNo48Zero, CountAllOnes
  } count_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  aips_req_if req_bus ();
  aips_rsp_if rsp_bus ();

  ata_identify_probe_sequencer_core #(
    .DELAY_READS(DelayReads)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  always #10 clk_i = ~clk_i;

  // predicted sequencer state
  probe_phase_e pr_phase      = PhIdle;
  logic [31:0]  pr_poll_limit = PollLimitReset;
  logic [31:0]  pr_polls      = '0;
  logic [8:0]   pr_step       = '0;
  logic         pr_chan       = 1'b0;
  logic         pr_drive      = 1'b0;
  logic         pr_lba48      = 1'b0;
  logic [31:0]  pr_count28    = '0;
  logic [63:0]  pr_count48    = '0;
  logic         pr_sig        = 1'b0;

  rsp_t pending_results[$];
  int   sent_total = 0;
  int   mismatches = 0;

  // stimulus plan for the running probe
  probe_phase_e fail_phase = PhIdle;
  logic         drq_stuck  = 1'b0;
  count_mode_e  cnt_mode   = CountRandom;
  logic         sender_gaps     = 1'b1;
  logic         hold_off_req    = 1'b0;
  logic         hold_off_active = 1'b0;

  function automatic logic [7:0] drive_code();
    return pr_drive ? DriveSlave : DriveMaster;
  endfunction

  function automatic rsp_t bus_access(logic wr, logic [3:0] rg, logic wide, logic [7:0] data);
    rsp_t r;
    r             = '0;
    r.report_kind = KindAccess;
    r.bus_channel = pr_chan;
    r.bus_write   = wr;
    r.bus_reg     = rg;
    r.bus_wide    = wide;
    r.bus_data    = data;
    return r;
  endfunction

  function automatic rsp_t probe_report(result_code_e code, logic pkt, logic l48,
                                        logic [63:0] cnt);
    rsp_t r;
    r                  = '0;
    pr_phase           = PhIdle;
    r.report_kind      = KindReport;
    r.bus_channel      = pr_chan;
    r.result_code      = code;
    r.is_packet_device = pkt;
    r.lba48_supported  = l48;
    r.sector_count     = cnt;
    return r;
  endfunction

  function automatic rsp_t begin_wait(probe_phase_e nxt);
    pr_polls = '0;
    if (pr_poll_limit == 0) return probe_report(ResTimeout, 1'b0, 1'b0, '0);
    pr_phase = nxt;
    return bus_access(1'b0, RegStatus, 1'b0, 8'h00);
  endfunction

  function automatic rsp_t poll_retry();
    pr_polls++;
    if (pr_polls >= pr_poll_limit) return probe_report(ResTimeout, 1'b0, 1'b0, '0);
    return bus_access(1'b0, RegStatus, 1'b0, 8'h00);
  endfunction

  // next result of the sequencer for one transfer, 0 when none is due
  function automatic bit probe_step(req_t it, output rsp_t r);
    logic [7:0]  b;
    logic [63:0] total;
    b = it.read_data[7:0];
    r = '0;
    if (it.command == CmdStart) begin
      pr_chan    = it.channel_select;
      pr_drive   = it.drive_select;
      pr_lba48   = 1'b0;
      pr_count28 = '0;
      pr_count48 = '0;
      pr_sig     = 1'b0;
      pr_polls   = '0;
      pr_step    = '0;
      pr_phase   = PhSelWr;
      r = bus_access(1'b1, RegDrive, 1'b0, drive_code());
      return 1'b1;
    end
    case (pr_phase)
      PhSelWr, PhSel2Wr: begin
        pr_step  = '0;
        pr_phase = (pr_phase == PhSelWr) ? PhSelDly : PhSel2Dly;
        r = bus_access(1'b0, RegAltStatus, 1'b0, 8'h00);
      end
      PhSelDly: begin
        pr_step++;
        if (pr_step < DelayReads) begin
          r = bus_access(1'b0, RegAltStatus, 1'b0, 8'h00);
        end else begin
          pr_phase = PhChk1;
          r = bus_access(1'b0, RegStatus, 1'b0, 8'h00);
        end
      end
      PhChk1, PhChk2: begin
        if (b == 8'h00) r = probe_report(ResNoDevice, 1'b0, 1'b0, '0);
        else r = begin_wait((pr_phase == PhChk1) ? PhBsy1 : PhBsy2);
      end
      PhBsy1: begin
        if (!b[StatBsy]) begin
          pr_phase = PhSel2Wr;
          r = bus_access(1'b1, RegDrive, 1'b0, drive_code());
        end else begin
          r = poll_retry();
        end
      end
      PhSel2Dly: begin
        pr_step++;
        if (pr_step < DelayReads) begin
          r = bus_access(1'b0, RegAltStatus, 1'b0, 8'h00);
        end else begin
          pr_step  = '0;
          pr_phase = PhClr;
          r = bus_access(1'b1, RegSectorCount, 1'b0, 8'h00);
        end
      end
      PhClr: begin
        pr_step++;
        if (pr_step < ClearRegs) begin
          r = bus_access(1'b1, RegSectorCount + pr_step[3:0], 1'b0, 8'h00);
        end else begin
          pr_phase = PhCmd;
          r = bus_access(1'b1, RegCommand, 1'b0, CmdIdentify);
        end
      end
      PhCmd: begin
        pr_phase = PhChk2;
        r = bus_access(1'b0, RegStatus, 1'b0, 8'h00);
      end
      PhBsy2: begin
        if (!b[StatBsy]) begin
          pr_phase = PhSigMid;
          r = bus_access(1'b0, RegLbaMid, 1'b0, 8'h00);
        end else begin
          r = poll_retry();
        end
      end
      PhSigMid: begin
        pr_sig   = (b != 8'h00);
        pr_phase = PhSigHigh;
        r = bus_access(1'b0, RegLbaHigh, 1'b0, 8'h00);
      end
      PhSigHigh: begin
        if (b != 8'h00) pr_sig = 1'b1;
        if (pr_sig) r = probe_report(ResNoDevice, 1'b1, 1'b0, '0);
        else r = begin_wait(PhDrq);
      end
      PhDrq: begin
        if (b[StatBsy]) begin
          r = poll_retry();
        end else if (b[StatErr] || b[StatDf]) begin
          r = probe_report(ResIoError, 1'b0, 1'b0, '0);
        end else if (b[StatDrq]) begin
          pr_step  = '0;
          pr_phase = PhData;
          r = bus_access(1'b0, RegData, 1'b1, 8'h00);
        end else begin
          r = poll_retry();
        end
      end
      PhData: begin
        if (pr_step == WordCountLo) pr_count28[15:0] = it.read_data;
        else if (pr_step == WordCountHi) pr_count28[31:16] = it.read_data;
        else if (pr_step == WordFeatures) pr_lba48 = it.read_data[Lba48Bit];
        else if (pr_step >= WordLbaFirst && pr_step <= WordLbaLast)
          pr_count48[16 * (pr_step - WordLbaFirst) +: 16] = it.read_data;
        pr_step++;
        if (pr_step < IdentifyWords) begin
          r = bus_access(1'b0, RegData, 1'b1, 8'h00);
        end else begin
          total = (pr_lba48 && pr_count48 != 0) ? pr_count48 : {32'h0, pr_count28};
          if (total == 0) r = probe_report(ResIoError, 1'b0, pr_lba48, '0);
          else r = probe_report(ResOk, 1'b0, pr_lba48, total);
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // read data that steers the running probe along its plan
  function automatic logic [15:0] pick_read();
    logic [15:0] w;
    int          sel;
    w = 16'($urandom);
    case (pr_phase)
      PhChk1, PhChk2: begin
        if (fail_phase == pr_phase) w[7:0] = 8'h00;
        else w[7:0] = 8'($urandom_range(1, 255));
      end
      PhBsy1, PhBsy2: begin
        w[StatBsy] = (fail_phase == pr_phase) || ($urandom_range(0, 3) == 0);
      end
      PhSigMid, PhSigHigh: begin
        if (fail_phase == pr_phase) w[7:0] = 8'($urandom_range(1, 255));
        else w[7:0] = 8'h00;
      end
      PhDrq: begin
        sel = (fail_phase != PhDrq) ? $urandom_range(0, 4) : drq_stuck ? $urandom_range(0, 1) : 5;
        if (sel == 0) begin
          w[StatBsy] = 1'b1;
        end else if (sel == 5) begin
          w[StatBsy] = 1'b0;
          w[StatErr] = 1'($urandom);
          w[StatDf]  = !w[StatErr] || 1'($urandom);
        end else begin
          w[StatBsy] = 1'b0;
          w[StatErr] = 1'b0;
          w[StatDf]  = 1'b0;
          w[StatDrq] = (sel != 1);
        end
      end
      PhData: begin
        if (cnt_mode == CountAllOnes) begin
          w = 16'hFFFF;
        end else if (pr_step == WordCountLo || pr_step == WordCountHi) begin
          if (cnt_mode == CountZero || cnt_mode == CountNo48Zero) w = '0;
        end else if (pr_step == WordFeatures) begin
          if (cnt_mode == CountNoLarge || cnt_mode == CountZero) w[Lba48Bit] = 1'b1;
          else if (cnt_mode == CountNo48 || cnt_mode == CountNo48Zero) w[Lba48Bit] = 1'b0;
        end else if (pr_step >= WordLbaFirst && pr_step <= WordLbaLast) begin
          if (cnt_mode == CountNoLarge || cnt_mode == CountZero) w = '0;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_item(command_e cmd, logic ch, logic drv, logic [15:0] data);
    req_t it;
    rsp_t want;
    int   gap;
    it.command        = cmd;
    it.channel_select = ch;
    it.drive_select   = drv;
    it.read_data      = data;
    @(negedge clk_i);
    req_bus.valid   = 1'b1;
    req_bus.payload = it;
    do begin
      @(posedge clk_i);
    end while (req_bus.ready !== 1'b1);
    sent_total++;
    if (probe_step(it, want)) begin
      pending_results.push_back(want);
    end
    gap = $urandom_range(0, 99);
    gap = !sender_gaps ? 0 : (gap < 65) ? 0 : (gap < 95) ? $urandom_range(1, 3) :
          $urandom_range(8, 25);
    if (gap > 0) begin
      @(negedge clk_i);
      req_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_poll_limit(logic [31:0] value);
    drain();
    @(negedge clk_i);
    cfg_we        = 1'b1;
    cfg_wdata     = value;
    pr_poll_limit = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_plan(probe_phase_e fail, logic stuck, count_mode_e mode);
    fail_phase = fail;
    drq_stuck  = stuck;
    cnt_mode   = mode;
  endtask

  // one probe from its start to its report; abort_at restarts it midway
  task automatic run_probe(logic ch, logic drv, int abort_at);
    int steps;
    steps = 0;
    send_item(CmdStart, ch, drv, 16'($urandom));
    while (pr_phase != PhIdle) begin
      steps++;
      if (steps == abort_at) send_item(CmdStart, 1'($urandom), 1'($urandom), 16'($urandom));
      else send_item(CmdComplete, 1'($urandom), 1'($urandom), pick_read());
    end
  endtask

  task automatic test_idle_completion();
    send_item(CmdComplete, 1'b0, 1'b1, 16'h0000);
    send_item(CmdComplete, 1'b1, 1'b0, 16'hFFFF);
  endtask

  task automatic test_no_device();
    set_plan(PhChk1, 1'b0, CountRandom);
    run_probe(1'b1, 1'b1, 0);
    set_plan(PhChk2, 1'b0, CountRandom);
    run_probe(1'b0, 1'b1, 0);
  endtask

  task automatic test_restart_and_packet();
    set_plan(PhSigMid, 1'b0, CountRandom);
    run_probe(1'b1, 1'b0, 3);
    set_plan(PhSigHigh, 1'b0, CountRandom);
    run_probe(1'b0, 1'b0, 0);
  endtask

  task automatic test_status_error();
    set_plan(PhDrq, 1'b0, CountRandom);
    run_probe(1'b1, 1'b1, 0);
  endtask

  task automatic test_poll_limits();
    set_poll_limit(32'd0);
    set_plan(PhIdle, 1'b0, CountRandom);
    run_probe(1'b0, 1'b0, 0);
    set_poll_limit(32'd1);
    set_plan(PhBsy1, 1'b0, CountRandom);
    run_probe(1'b1, 1'b0, 0);
    set_poll_limit(32'd2);
    set_plan(PhBsy2, 1'b0, CountRandom);
    run_probe(1'b0, 1'b1, 0);
    set_poll_limit(32'd3);
    set_plan(PhDrq, 1'b1, CountRandom);
    run_probe(1'b1, 1'b1, 0);
  endtask

  task automatic test_sector_counts();
    set_poll_limit(32'hFFFF_FFFF);
    set_plan(PhIdle, 1'b0, count_mode_e'($urandom_range(0, CountAllOnes)));
    run_probe(1'($urandom), 1'($urandom), 0);
  endtask

  task automatic test_backpressure();
    set_plan(PhChk2, 1'b0, CountRandom);
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    wait (hold_off_active === 1'b1);
    run_probe(1'b1, 1'b0, 0);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random();
    probe_phase_e fail;
    logic         stuck;
    do begin
      case ($urandom_range(0, 2))
        0: set_poll_limit(32'($urandom_range(2, 6)));
        1: set_poll_limit(32'd1);
        default: set_poll_limit(32'hFFFF_FFFF);
      endcase
      case ($urandom_range(0, 7))
        0: fail = PhChk1;
        1: fail = PhBsy1;
        2: fail = PhChk2;
        3: fail = PhBsy2;
        4: fail = PhSigMid;
        5: fail = PhSigHigh;
        default: fail = PhDrq;
      endcase
      stuck = 1'($urandom);
      if (pr_poll_limit > 64 && (fail == PhBsy1 || fail == PhBsy2 ||
          (fail == PhDrq && stuck)))
        fail = PhSigHigh;
      set_plan(fail, stuck, CountRandom);
      run_probe(1'($urandom), 1'($urandom),
                ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0);
      if ($urandom_range(0, 3) == 0)
        send_item(CmdComplete, 1'($urandom), 1'($urandom), 16'($urandom));
    end while (sent_total < ItemTarget);
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = rsp_bus.payload;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("report_kind", want.report_kind, got.report_kind);
        compare_field("bus_channel", want.bus_channel, got.bus_channel);
        compare_field("bus_write", want.bus_write, got.bus_write);
        compare_field("bus_reg", want.bus_reg, got.bus_reg);
        compare_field("bus_wide", want.bus_wide, got.bus_wide);
        compare_field("bus_data", want.bus_data, got.bus_data);
        compare_field("result_code", want.result_code, got.result_code);
        compare_field("is_packet_device", want.is_packet_device, got.is_packet_device);
        compare_field("lba48_supported", want.lba48_supported, got.lba48_supported);
        compare_field("sector_count", want.sector_count, got.sector_count);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int run;
    int gap;
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i);
        rsp_bus.ready   = 1'b0;
        hold_off_active = 1'b1;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_off_active = 1'b0;
        hold_off_req    = 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
        @(negedge clk_i);
        rsp_bus.ready = 1'b1;
        repeat (run - 1) @(negedge clk_i);
        gap = $urandom_range(0, 99);
        gap = (gap < 50) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        if (gap > 0) begin
          @(negedge clk_i);
          rsp_bus.ready = 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_completion();
    test_no_device();
    test_restart_and_packet();
    test_status_error();
    test_poll_limits();
    test_backpressure();
    test_sector_counts();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
